@@ hdl/wsd_pkg.sv @@
`timescale 1ns / 1ps

package wsd_pkg;

  // Ring geometry: DEPTH must be a power of two
  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int VW    = 32;

  // Operation codes on the input channel (code 3 is unused)
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_STEAL = 2'd2
  } op_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

@@ hdl/work_stealing_deque_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_op[1:0], in_value[31:0]
// out_      output     out_valid / out_ready  out_ok, out_value_out[31:0], out_entries[8:0]
//
// The result of a push, a failed operation or an unused code is registered at
// the accepting edge. A pop or steal that finds entries first reads the ring
// memory through its registered read port; its result is registered in ST_READ.
// Reset clears the pointers, the count and the per-entry valid bits, so the
// ring reads as all null at once; no clearing pass is needed.
// A new item is taken while a result waits only if out_ready frees the
// output register in the same cycle.

module work_stealing_deque_top
  import wsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [VW-1:0] in_value,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_ok,
  output logic [VW-1:0] out_value_out,
  output logic [CW-1:0] out_entries
);

  // Control state
  state_t           state_r, state_nxt;
  logic [AW-1:0]    top_r, top_nxt;
  logic [AW-1:0]    bot_r, bot_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers
  logic             out_ok_r, out_ok_nxt;
  logic [VW-1:0]    out_val_r, out_val_nxt;
  logic [CW-1:0]    out_cnt_r, out_cnt_nxt;
  logic             op_pop_r, op_pop_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;

  // Ring memory
  logic [VW-1:0]    ring_mem [DEPTH];
  logic [VW-1:0]    rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VW-1:0]    wr_data;

  logic             accept;
  logic             is_push, is_pop, is_steal;
  logic             not_empty;
  logic [VW-1:0]    entry_val;

  assign is_push   = (in_op == OP_PUSH);
  assign is_pop    = (in_op == OP_POP);
  assign is_steal  = (in_op == OP_STEAL);
  assign not_empty = (cnt_r != '0);
  assign accept    = in_valid && in_ready;

  // Unwritten or removed entries read as null
  assign entry_val = vld_r[addr_r] ? rd_data_r : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (is_pop || is_steal) && not_empty) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory control
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = top_r;
    wr_en    = 1'b0;
    wr_addr  = bot_r;
    wr_data  = in_value;
    case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        rd_en    = accept && (is_pop || is_steal) && not_empty;
        rd_addr  = is_pop ? AW'(bot_r - 1'b1) : top_r;
        wr_en    = accept && is_push && (cnt_r < CW'(DEPTH));
      end
      ST_READ: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Pointer, count and result update
  always_comb begin
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    cnt_nxt       = cnt_r;
    vld_nxt       = vld_r;
    op_pop_nxt    = op_pop_r;
    addr_nxt      = addr_r;
    out_ok_nxt    = out_ok_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (state_r == ST_READ) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = 1'b0;
      out_val_nxt   = '0;
      if (op_pop_r) begin
        // pop always removes, even a null entry
        vld_nxt[addr_r] = 1'b0;
        if (cnt_r == CW'(1)) begin
          top_nxt = AW'(top_r + 1'b1);
        end else begin
          bot_nxt = addr_r;
        end
        cnt_nxt     = CW'(cnt_r - 1'b1);
        out_ok_nxt  = 1'b1;
        out_val_nxt = entry_val;
      end else if (entry_val != '0) begin
        // steal leaves a null entry in place
        vld_nxt[addr_r] = 1'b0;
        top_nxt         = AW'(top_r + 1'b1);
        cnt_nxt         = CW'(cnt_r - 1'b1);
        out_ok_nxt      = 1'b1;
        out_val_nxt     = entry_val;
      end
      out_cnt_nxt = cnt_nxt;
    end else if (accept) begin
      if (rd_en) begin
        op_pop_nxt = is_pop;
        addr_nxt   = rd_addr;
      end else begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b0;
        out_val_nxt   = '0;
        if (wr_en) begin
          vld_nxt[bot_r] = 1'b1;
          bot_nxt        = AW'(bot_r + 1'b1);
          cnt_nxt        = CW'(cnt_r + 1'b1);
          out_ok_nxt     = 1'b1;
        end
        out_cnt_nxt = cnt_nxt;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= '0;
      bot_r       <= '0;
      cnt_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_ok_r  <= out_ok_nxt;
    out_val_r <= out_val_nxt;
    out_cnt_r <= out_cnt_nxt;
    op_pop_r  <= op_pop_nxt;
    addr_r    <= addr_nxt;
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_value_out = out_val_r;
  assign out_entries   = out_cnt_r;

endmodule
